@@ hdl/u8dec_pkg.sv @@
package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CNT_W  = 3;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_ILLEGAL    = 2'd1;
    localparam logic [ST_W-1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [CNT_W-1:0] LEN1     = 3'd1;
    localparam logic [CNT_W-1:0] LEN2     = 3'd2;
    localparam logic [CNT_W-1:0] LEN3     = 3'd3;
    localparam logic [CNT_W-1:0] LEN4     = 3'd4;

    localparam logic [1:0] REM_IDLE = 2'd0;
    localparam logic [1:0] REM_ONE  = 2'd1;
    localparam logic [1:0] REM_TWO  = 2'd2;
    localparam logic [1:0] REM_THREE = 2'd3;

    typedef enum logic [2:0] {
        KIND_ASCII = 3'd0,
        KIND_LEAD2 = 3'd1,
        KIND_LEAD3 = 3'd2,
        KIND_LEAD4 = 3'd3,
        KIND_BAD   = 3'd4
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        kind;
        logic              cont_ok;
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_item_t;

    function automatic logic value_bad(logic [CNT_W-1:0] len, logic [CP_W-1:0] v);
        logic [15:0] lo;
        logic        bad;
        lo  = v[15:0];
        bad = 1'b0;
        if (len == LEN3) begin
            bad = (v < 21'h000800) ||
                  (v >= 21'h00D800 && v <= 21'h00DFFF) ||
                  (v >= 21'h00FDD0 && v <= 21'h00FDEF) ||
                  (v == 21'h00FFFE) || (v == 21'h00FFFF);
        end else if (len == LEN4) begin
            bad = (v < 21'h010000) || (v > 21'h10FFFF) ||
                  (lo == 16'hFFFE) || (lo == 16'hFFFF);
        end
        return bad;
    endfunction

endpackage

@@ hdl/utf8_byte_stream_decoder.sv @@
// Decodes a stream of UTF-8 bytes, one byte per transaction, into Unicode scalar values.
// The block accepts one byte per clock cycle while its queue has room; a byte passes the
// classifying front end into a small queue, and the sequence assembler behind it takes one
// queued byte per cycle while its output register is empty or being read, and registers
// each result there. Multi-byte sequences give no result until their last byte. Illegal bytes,
// overlong forms, surrogates, noncharacters and values above 10FFFF give an illegal result
// at the byte where they are detected, and a sequence left open by a byte with tlast set
// gives an incomplete result. Error results carry zero code point and zero byte count.
module utf8_byte_stream_decoder
    import u8dec_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] byte_count
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic             q_ready;
    logic             q_push;
    byte_item_t       push_item;
    logic             q_valid;
    logic             q_pop;
    byte_item_t       pop_item;
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] byte_count;

    u8dec_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    u8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .in_ready  (q_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_item  (pop_item)
    );

    u8dec_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_code_point (code_point),
        .m_status     (m_tuser),
        .m_byte_count (byte_count)
    );

    assign m_tdata = {byte_count, code_point};

endmodule

@@ hdl/u8dec_front.sv @@
module u8dec_front
    import u8dec_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              s_last,
    input  logic              q_ready,
    output logic              q_push,
    output byte_item_t        q_item
);

    byte_kind_t kind;

    always_comb begin
        if (s_byte <= 8'h7F) begin
            kind = KIND_ASCII;
        end else if (s_byte >= 8'hC2 && s_byte <= 8'hDF) begin
            kind = KIND_LEAD2;
        end else if (s_byte >= 8'hE0 && s_byte <= 8'hEF) begin
            kind = KIND_LEAD3;
        end else if (s_byte >= 8'hF0 && s_byte <= 8'hF4) begin
            kind = KIND_LEAD4;
        end else begin
            kind = KIND_BAD;
        end
    end

    assign s_tready       = q_ready;
    assign q_push         = s_tvalid & q_ready;
    assign q_item.kind    = kind;
    assign q_item.cont_ok = (s_byte[7:6] == 2'b10);
    assign q_item.data    = s_byte;
    assign q_item.last    = s_last;

endmodule

@@ hdl/u8dec_queue.sv @@
module u8dec_queue
    import u8dec_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  byte_item_t push_item,
    output logic       in_ready,
    input  logic       pop,
    output logic       out_valid,
    output byte_item_t out_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

    byte_item_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign in_ready  = (count_reg != CNT_W_Q'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_push   = push & in_ready;
    assign do_pop    = pop & out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/u8dec_back.sv @@
module u8dec_back
    import u8dec_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  byte_item_t       q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [CP_W-1:0]  m_code_point,
    output logic [ST_W-1:0]  m_status,
    output logic [CNT_W-1:0] m_byte_count
);

    logic [1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             take;
    logic             emit;
    logic             opened;
    logic [CP_W-1:0]  acc_shift;
    logic [1:0]       rem_dec;
    logic [CP_W-1:0]  res_cp;
    logic [ST_W-1:0]  res_st;
    logic [CNT_W-1:0] res_cnt;

    assign take      = q_valid & (~valid_reg | m_tready);
    assign q_pop     = take;
    assign acc_shift = {acc_reg[CP_W-7:0], q_item.data[5:0]};
    assign rem_dec   = rem_reg - 2'd1;

    always_comb begin
        rem_next = rem_reg;
        len_next = len_reg;
        acc_next = acc_reg;
        emit     = 1'b0;
        opened   = 1'b0;
        res_cp   = '0;
        res_st   = ST_OK;
        res_cnt  = LEN_NONE;
        if (take) begin
            if (rem_reg == REM_IDLE) begin
                unique case (q_item.kind)
                    KIND_ASCII: begin
                        emit    = 1'b1;
                        res_cp  = {13'd0, q_item.data};
                        res_cnt = LEN1;
                    end
                    KIND_LEAD2: begin
                        opened   = 1'b1;
                        len_next = LEN2;
                        rem_next = REM_ONE;
                        acc_next = {16'd0, q_item.data[4:0]};
                    end
                    KIND_LEAD3: begin
                        opened   = 1'b1;
                        len_next = LEN3;
                        rem_next = REM_TWO;
                        acc_next = {17'd0, q_item.data[3:0]};
                    end
                    KIND_LEAD4: begin
                        opened   = 1'b1;
                        len_next = LEN4;
                        rem_next = REM_THREE;
                        acc_next = {18'd0, q_item.data[2:0]};
                    end
                    default: begin
                        emit   = 1'b1;
                        res_st = ST_ILLEGAL;
                    end
                endcase
                if (opened && q_item.last) begin
                    emit     = 1'b1;
                    res_st   = ST_INCOMPLETE;
                    rem_next = REM_IDLE;
                    len_next = LEN_NONE;
                end
            end else if (!q_item.cont_ok) begin
                emit     = 1'b1;
                res_st   = ST_ILLEGAL;
                rem_next = REM_IDLE;
                len_next = LEN_NONE;
            end else begin
                acc_next = acc_shift;
                rem_next = rem_dec;
                if (rem_dec == REM_IDLE) begin
                    emit     = 1'b1;
                    len_next = LEN_NONE;
                    if (value_bad(len_reg, acc_shift)) begin
                        res_st = ST_ILLEGAL;
                    end else begin
                        res_cp  = acc_shift;
                        res_cnt = len_reg;
                    end
                end else if (q_item.last) begin
                    emit     = 1'b1;
                    res_st   = ST_INCOMPLETE;
                    rem_next = REM_IDLE;
                    len_next = LEN_NONE;
                end
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        cp_next    = cp_reg;
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        if (take) begin
            valid_next = emit;
            cp_next    = res_cp;
            st_next    = res_st;
            cnt_next   = res_cnt;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= REM_IDLE;
            len_reg   <= LEN_NONE;
            valid_reg <= 1'b0;
        end else begin
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        cp_reg  <= cp_next;
        st_reg  <= st_next;
        cnt_reg <= cnt_next;
    end

    assign m_tvalid     = valid_reg;
    assign m_code_point = cp_reg;
    assign m_status     = st_reg;
    assign m_byte_count = cnt_reg;

    a_idle_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg == REM_IDLE) |-> (len_reg == LEN_NONE))
        else $error("Idle decoder holds a sequence length.");

    a_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != REM_IDLE) |-> (len_reg > {1'b0, rem_reg} && len_reg <= LEN4))
        else $error("Open sequence length disagrees with bytes remaining.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && st_reg != ST_OK) |-> (cp_reg == '0 && cnt_reg == LEN_NONE))
        else $error("Error result carries a code point or byte count.");

    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && st_reg == ST_OK) |-> (cnt_reg != LEN_NONE && cnt_reg <= LEN4))
        else $error("Good result has an invalid byte count.");

    a_ascii_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && st_reg == ST_OK && cnt_reg == LEN1) |-> (cp_reg < 21'h80))
        else $error("One-byte result is outside the ASCII range.");

endmodule

@@ dv/tb_utf8_byte_stream_decoder.sv @@
module tb_utf8_byte_stream_decoder;
    import u8dec_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] byte_count;
    } decoded_symbol_t;

    class utf8_scoreboard;
        logic [1:0]       remaining;
        logic [CNT_W-1:0] seq_len;
        logic [CP_W-1:0]  acc;
        decoded_symbol_t  pending[$];
        int               mismatches;

        function new();
            clear_sequence();
            mismatches = 0;
        endfunction

        function void clear_sequence();
            remaining = REM_IDLE;
            seq_len   = LEN_NONE;
            acc       = '0;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("t=%0t %s", $time, what);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            decoded_symbol_t sym;
            bit              emit;
            bit              bad;
            logic [15:0]     lo;
            emit = 1'b0;
            sym.code_point = '0;
            sym.status     = ST_ILLEGAL;
            sym.byte_count = LEN_NONE;
            if (remaining == REM_IDLE) begin
                if (b <= 8'h7F) begin
                    sym.code_point = CP_W'(b);
                    sym.status     = ST_OK;
                    sym.byte_count = LEN1;
                    emit = 1'b1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                    seq_len = LEN2;
                    acc     = CP_W'(b[4:0]);
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                    seq_len = LEN3;
                    acc     = CP_W'(b[3:0]);
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                    seq_len = LEN4;
                    acc     = CP_W'(b[2:0]);
                end else begin
                    emit = 1'b1;
                end
                if (!emit) begin
                    remaining = 2'(seq_len - 3'd1);
                    if (last) begin
                        sym.status = ST_INCOMPLETE;
                        emit = 1'b1;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                emit = 1'b1;
            end else begin
                acc       = {acc[CP_W-7:0], b[5:0]};
                remaining = remaining - 2'd1;
                if (remaining == REM_IDLE) begin
                    lo  = acc[15:0];
                    bad = 1'b0;
                    if (seq_len == LEN3) begin
                        bad = acc < 21'h000800 || (acc >= 21'h00D800 && acc <= 21'h00DFFF) ||
                              (acc >= 21'h00FDD0 && acc <= 21'h00FDEF) ||
                              lo == 16'hFFFE || lo == 16'hFFFF;
                    end else if (seq_len == LEN4) begin
                        bad = acc < 21'h010000 || acc > 21'h10FFFF ||
                              lo == 16'hFFFE || lo == 16'hFFFF;
                    end
                    if (!bad) begin
                        sym.code_point = acc;
                        sym.status     = ST_OK;
                        sym.byte_count = seq_len;
                    end
                    emit = 1'b1;
                end else if (last) begin
                    sym.status = ST_INCOMPLETE;
                    emit = 1'b1;
                end
            end
            if (emit) begin
                clear_sequence();
                pending.push_back(sym);
            end
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic [ST_W-1:0] st,
                                   logic [CNT_W-1:0] cnt);
            decoded_symbol_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result cp=%h status=%0d count=%0d", cp, st, cnt));
                return;
            end
            want = pending.pop_front();
            if (cp !== want.code_point || st !== want.status || cnt !== want.byte_count) begin
                report($sformatf("expected cp=%h status=%0d count=%0d, got cp=%h status=%0d count=%0d",
                                 want.code_point, want.status, want.byte_count, cp, st, cnt));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    utf8_scoreboard sb;
    bit             no_idle = 1'b0;
    int             bytes_sent = 0;

    logic [8:0] directed_bytes[] = '{
        9'h000, 9'h17F,
        9'h0C2, 9'h080,
        9'h0E0, 9'h09F, 9'h0BF,
        9'h0ED, 9'h0A0, 9'h080,
        9'h0EF, 9'h0B7, 9'h090,
        9'h0EF, 9'h0BF, 9'h0BF,
        9'h0F4, 9'h090, 9'h080, 9'h080,
        9'h080, 9'h0C1, 9'h0F5, 9'h1FF,
        9'h0C2, 9'h041,
        9'h0E1, 9'h180,
        9'h1C3
    };

    utf8_byte_stream_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_sequence(input int len, input int conts, input bit end_buf);
        logic [7:0] lead;
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7F));
            2: lead = 8'($urandom_range(8'hC2, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
        send_byte(lead, end_buf && conts == 0);
        for (int i = 1; i <= conts; i++) begin
            send_byte(8'($urandom_range(8'h80, 8'hBF)), end_buf && i == conts);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata[20:0], m_tuser, m_tdata[23:21]);
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("utf8_byte_stream_decoder: mismatch");
        $finish;
    end

    initial begin
        int kind;
        int len;
        int guard;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        end

        // Mostly complete sequences with random content, some cut short, some raw noise.
        while (bytes_sent < 1600) begin
            if ($urandom_range(0, 99) == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                len = $urandom_range(1, 4);
                send_sequence(len, len - 1, $urandom_range(0, 7) == 0);
            end else if (kind < 85) begin
                len = $urandom_range(2, 4);
                send_sequence(len, $urandom_range(0, len - 2), $urandom_range(0, 1) == 1);
            end else begin
                send_byte(8'($urandom()), 1'($urandom_range(0, 1)));
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);

        if (sb.pending.size() != 0) begin
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
        end
        if (sb.mismatches == 0) begin
            $display("utf8_byte_stream_decoder: match");
        end else begin
            $display("utf8_byte_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule
